@@ rtl/bwgr_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bwgr_pkg: shared definitions of the Braille waveform glyph raster
// Operation codes, register indexes, field widths, reset values, the Braille
// dot table and the status record of the serial divider.
// ============================================================================
package bwgr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_SAMPLES = 2048;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_COLS    = 256;

    // Fixed field widths of the request and result items.
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 12;
    localparam int VAL_W    = 16;
    localparam int CROW_W   = 6;
    localparam int CCOL_W   = 8;
    localparam int S_DATA_W = 48;
    localparam int PAT_W    = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 2'd1;
    localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RESET = 7'd16;
    localparam logic [COLS_CFG_W-1:0] GRID_COLS_RESET = 9'd80;

    // Operation codes carried in tuser.
    localparam logic [FUNC_W-1:0] FUNC_STORE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

    // Status of the serial divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Braille dot bit for dot row dr (top to bottom) and dot column dc.
    function automatic logic [PAT_W-1:0] dot_bit(input logic [1:0] dr, input logic dc);
        logic [PAT_W-1:0] bits;
        unique case ({dr, dc})
            3'b000:  bits = 8'h01;
            3'b001:  bits = 8'h08;
            3'b010:  bits = 8'h02;
            3'b011:  bits = 8'h10;
            3'b100:  bits = 8'h04;
            3'b101:  bits = 8'h20;
            3'b110:  bits = 8'h40;
            3'b111:  bits = 8'h80;
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

@@ rtl/bwgr_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bwgr_div: restoring serial divider
// Unsigned division, one quotient bit per clock. The divisor must stay stable
// while the division runs; the quotient holds until the next start.
// ============================================================================
module bwgr_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output logic [NUM_W-1:0]     quotient,
    output bwgr_pkg::div_stat_t  stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             q_bit;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        q_bit = (trial >= {1'b0, divisor});
        if (q_bit)
        begin
            rem_next = DEN_W'(trial - {1'b0, divisor});
        end
        else
        begin
            rem_next = DEN_W'(trial);
        end
        quo_next = {quo_reg[NUM_W-2:0], q_bit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ rtl/braille_waveform_glyph_raster.sv @@
`timescale 1ns / 1ps
// ============================================================================
// braille_waveform_glyph_raster: Braille oscilloscope glyph renderer
// Holds a window of Q1.15 samples and returns the Braille dot pattern of one
// glyph cell of the waveform trace per query request.
// ============================================================================
// A store request (func 0) and a count request (func 1) produce no result
// and leave the block idle; func 3 is ignored in the same cycle. A query
// (func 2) for a cell outside the configured grid goes straight to the
// finish step and returns dot pattern 0 with the out_of_grid flag. A query
// inside the grid evaluates three dot columns (the cell's two and the one to
// its left, only two for the leftmost cell). The serial divider forms the
// sample index x*count/(2*cols) one quotient bit per cycle over PW bits, the
// width of x*count; with the default sizes PW is 21. With a valid count of
// zero no division or read is needed. The block takes no new request while
// a query is in progress, but it does accept one while a finished result
// waits on the output register. Configuration writes are always accepted and
// must only be issued while the block is idle. The sample store has no
// reset; reading an unwritten entry gives an undefined pattern.
// ============================================================================
module braille_waveform_glyph_raster #(
    parameter int MAX_SAMPLES = bwgr_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_ROWS    = bwgr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = bwgr_pkg::DEF_MAX_COLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Request stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // tdata from bit 0 up: sample_index[11:0], sample_value[27:12],
    // cell_row[33:28], cell_col[41:34], zero padding[47:42].
    input  logic [bwgr_pkg::S_DATA_W-1:0]    s_tdata,
    // tuser: func[1:0].
    input  logic [bwgr_pkg::FUNC_W-1:0]      s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // tdata: dot_pattern[7:0].
    output logic [bwgr_pkg::PAT_W-1:0]       m_tdata,
    // tuser: out_of_grid[0].
    output logic                             m_tuser,
    // Configuration write channel.
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bwgr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bwgr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Derived widths.
    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1; // store address
    localparam int CW  = $clog2(MAX_SAMPLES + 1);          // valid count
    localparam int EW  = ((bwgr_pkg::IDX_W > CW) ? bwgr_pkg::IDX_W : CW) + 1;
    localparam int RW  = $clog2(MAX_ROWS + 1);             // glyph rows
    localparam int DW  = $clog2(4 * MAX_ROWS + 1);         // dot rows
    localparam int YW  = $clog2(4 * MAX_ROWS);             // dot row index
    localparam int KW  = $clog2(MAX_COLS + 1);             // glyph columns
    localparam int CDW = $clog2(2 * MAX_COLS + 1);         // dot columns
    localparam int XW  = (MAX_COLS > 0) ? $clog2(2 * MAX_COLS) : 1; // dot column index
    localparam int PW  = XW + CW;                           // x*count
    localparam int OFF_W = 17;                              // 32768 - s
    localparam int MA  = (CW > OFF_W) ? CW : OFF_W;
    localparam int MB  = (XW > DW) ? XW : DW;
    localparam int PRW = MA + MB;
    localparam int YFW = PRW - 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_DIV_GO,
        S_DIV_WAIT,
        S_READ,
        S_MULY,
        S_YSTORE,
        S_FINISH
    } state_t;

    // Request fields.
    logic [bwgr_pkg::FUNC_W-1:0] func;
    logic [bwgr_pkg::IDX_W-1:0]  sidx;
    logic [bwgr_pkg::VAL_W-1:0]  sval;
    logic [bwgr_pkg::CROW_W-1:0] crow;
    logic [bwgr_pkg::CCOL_W-1:0] ccol;
    logic [EW-1:0]               sidx_ext;
    logic                        accept;

    assign func     = s_tuser;
    assign sidx     = s_tdata[11:0];
    assign sval     = s_tdata[27:12];
    assign crow     = s_tdata[33:28];
    assign ccol     = s_tdata[41:34];
    assign sidx_ext = EW'(sidx);
    assign accept   = s_tvalid && s_tready;

    // Configuration registers; a write to an index beyond the list is dropped.
    logic [bwgr_pkg::ROWS_CFG_W-1:0] grid_rows_reg;
    logic [bwgr_pkg::COLS_CFG_W-1:0] grid_cols_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg <= bwgr_pkg::GRID_ROWS_RESET;
            grid_cols_reg <= bwgr_pkg::GRID_COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == bwgr_pkg::REG_GRID_ROWS)
            begin
                grid_rows_reg <= cfg_data[bwgr_pkg::ROWS_CFG_W-1:0];
            end
            else if (cfg_index == bwgr_pkg::REG_GRID_COLS)
            begin
                grid_cols_reg <= cfg_data[bwgr_pkg::COLS_CFG_W-1:0];
            end
        end
    end

    // Register values above the supported grid act as the maximum.
    logic [RW-1:0] rows_eff;
    logic [KW-1:0] cols_eff;

    assign rows_eff = (32'(grid_rows_reg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(grid_rows_reg);
    assign cols_eff = (32'(grid_cols_reg) > MAX_COLS) ? KW'(MAX_COLS) : KW'(grid_cols_reg);

    // Valid sample count, saturated at the store size.
    logic [CW-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept && (func == bwgr_pkg::FUNC_COUNT))
        begin
            if (sidx_ext > EW'(MAX_SAMPLES))
            begin
                count_reg <= CW'(MAX_SAMPLES);
            end
            else
            begin
                count_reg <= CW'(sidx_ext);
            end
        end
    end

    // Sequencer state and query context.
    state_t                      state;
    logic [bwgr_pkg::CROW_W-1:0] crow_reg;
    logic [bwgr_pkg::CCOL_W-1:0] ccol_reg;
    logic [RW-1:0]               rows_reg;
    logic [KW-1:0]               cols_reg;
    logic [1:0]                  col_sel_reg;
    logic                        oog_reg;
    logic [PRW-1:0]              prod_reg;
    logic [YW-1:0]               y0_reg;   // dot column 2*col
    logic [YW-1:0]               y1_reg;   // dot column 2*col+1
    logic [YW-1:0]               ym_reg;   // dot column 2*col-1
    logic                        m_tvalid_reg;
    logic [bwgr_pkg::PAT_W-1:0]  m_tdata_reg;
    logic                        m_tuser_reg;

    assign s_tready = (state == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Sample store: written on a store request, read once per dot column when the valid count is not zero.
    logic [bwgr_pkg::VAL_W-1:0] sample_store [MAX_SAMPLES];
    logic [bwgr_pkg::VAL_W-1:0] rd_data_reg;
    logic [PW-1:0]              div_quo;

    always_ff @(posedge clk)
    begin
        if (accept && (func == bwgr_pkg::FUNC_STORE) && (sidx_ext < EW'(MAX_SAMPLES)))
        begin
            sample_store[sidx_ext[AW-1:0]] <= sval;
        end
        if (state == S_READ)
        begin
            rd_data_reg <= sample_store[div_quo[AW-1:0]];
        end
    end

    // Geometry of the query in dot units.
    logic [DW-1:0]  dm1;        // dot rows - 1
    logic [CDW-1:0] dcols;      // dot columns
    logic [XW-1:0]  x_base;
    logic [XW-1:0]  x_cur;

    assign dm1    = DW'({rows_reg, 2'b00}) - DW'(1);
    assign dcols  = CDW'({cols_reg, 1'b0});
    assign x_base = XW'({ccol_reg, 1'b0});

    always_comb
    begin
        unique case (col_sel_reg)
            2'd0:    x_cur = x_base;
            2'd1:    x_cur = x_base + XW'(1);
            2'd2:    x_cur = x_base - XW'(1);
            default: x_cur = x_base;
        endcase
    end

    // Shared multiplier: x*count for the sample index, then the level scaling.
    logic signed [bwgr_pkg::VAL_W-1:0] samp;
    logic [OFF_W-1:0]                  s_off;
    logic [MA-1:0]                     mul_a;
    logic [MB-1:0]                     mul_b;
    logic [PRW-1:0]                    mul_p;

    // With no valid samples every column reads level zero, the centre line.
    assign samp  = (count_reg == '0) ? '0 : rd_data_reg;
    assign s_off = OFF_W'(17'd32768 - {samp[bwgr_pkg::VAL_W-1], samp});

    always_comb
    begin
        if (state == S_MULX)
        begin
            mul_a = MA'(count_reg);
            mul_b = MB'(x_cur);
        end
        else
        begin
            mul_a = MA'(s_off);
            mul_b = MB'(dm1);
        end
        mul_p = PRW'(mul_a) * PRW'(mul_b);
    end

    // Dot row from the scaled level, clamped to the bottom row.
    logic [YFW-1:0] y_full;
    logic [YW-1:0]  y_new;

    assign y_full = prod_reg[PRW-1:16];
    assign y_new  = (y_full > YFW'(dm1)) ? YW'(dm1) : YW'(y_full);

    // Serial divider for the sample index x*count / dot columns.
    bwgr_pkg::div_stat_t div_stat;

    bwgr_div #(
        .NUM_W (PW),
        .DEN_W (CDW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state == S_DIV_GO),
        .dividend (prod_reg[PW-1:0]),
        .divisor  (dcols),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    // Glyph pattern: in each dot column, light the rows between its level and
    // the level of the column to its left. The leftmost cell uses its own level.
    logic [bwgr_pkg::PAT_W-1:0] pattern;
    logic [YW-1:0]              y_left;
    logic [YW-1:0]              ya;
    logic [YW-1:0]              yb;
    logic [YW-1:0]              lo;
    logic [YW-1:0]              hi;
    logic [YW-1:0]              dy;

    always_comb
    begin
        pattern = '0;
        y_left  = (ccol_reg == '0) ? y0_reg : ym_reg;
        ya      = '0;
        yb      = '0;
        lo      = '0;
        hi      = '0;
        dy      = '0;
        for (int dc = 0; dc < 2; dc++)
        begin
            ya = (dc == 0) ? y0_reg : y1_reg;
            yb = (dc == 0) ? y_left : y0_reg;
            lo = (ya < yb) ? ya : yb;
            hi = (ya < yb) ? yb : ya;
            for (int dr = 0; dr < 4; dr++)
            begin
                dy = YW'({crow_reg, 2'(dr)});
                if ((dy >= lo) && (dy <= hi))
                begin
                    pattern = pattern | bwgr_pkg::dot_bit(2'(dr), 1'(dc));
                end
            end
        end
    end

    // Sequencer: per dot column multiply, divide and read (nonzero count), scale, store level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state        <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            col_sel_reg  <= 2'd0;
            oog_reg      <= 1'b0;
            crow_reg     <= '0;
            ccol_reg     <= '0;
            rows_reg     <= '0;
            cols_reg     <= '0;
            prod_reg     <= '0;
            y0_reg       <= '0;
            y1_reg       <= '0;
            ym_reg       <= '0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= 1'b0;
        end
        else
        begin
            // The finish step reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state != S_FINISH))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state)
                S_IDLE:
                begin
                    if (accept && (func == bwgr_pkg::FUNC_QUERY))
                    begin
                        crow_reg    <= crow;
                        ccol_reg    <= ccol;
                        rows_reg    <= rows_eff;
                        cols_reg    <= cols_eff;
                        col_sel_reg <= 2'd0;
                        if ((32'(crow) >= 32'(rows_eff)) || (32'(ccol) >= 32'(cols_eff)))
                        begin
                            oog_reg <= 1'b1;
                            state   <= S_FINISH;
                        end
                        else
                        begin
                            oog_reg <= 1'b0;
                            state   <= S_MULX;
                        end
                    end
                end
                S_MULX:
                begin
                    prod_reg <= mul_p;
                    if (count_reg == '0)
                    begin
                        state <= S_MULY;
                    end
                    else
                    begin
                        state <= S_DIV_GO;
                    end
                end
                S_DIV_GO:
                begin
                    state <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        state <= S_READ;
                    end
                end
                S_READ:
                begin
                    state <= S_MULY;
                end
                S_MULY:
                begin
                    prod_reg <= mul_p;
                    state    <= S_YSTORE;
                end
                S_YSTORE:
                begin
                    unique case (col_sel_reg)
                        2'd0:    y0_reg <= y_new;
                        2'd1:    y1_reg <= y_new;
                        default: ym_reg <= y_new;
                    endcase
                    if ((col_sel_reg == 2'd2) || ((col_sel_reg == 2'd1) && (ccol_reg == '0)))
                    begin
                        state <= S_FINISH;
                    end
                    else
                    begin
                        col_sel_reg <= col_sel_reg + 2'd1;
                        state       <= S_MULX;
                    end
                end
                S_FINISH:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= oog_reg ? '0 : pattern;
                        m_tuser_reg  <= oog_reg;
                        state        <= S_IDLE;
                    end
                end
                default:
                begin
                    state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/bwgr_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bwgr_checker: port-level checks of the glyph raster
// Watches the streams of the top level and is bound to it.
// ============================================================================
module bwgr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [bwgr_pkg::FUNC_W-1:0]      s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bwgr_pkg::PAT_W-1:0]       m_tdata,
    input logic                             m_tuser
);

    // A stalled result holds its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An out-of-grid result carries an empty pattern.
    a_oog_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("out-of-grid result with lit dots");

    // A query keeps the block busy in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == bwgr_pkg::FUNC_QUERY) |=> !s_tready)
        else $error("ready right after a query");

    // Store, count and unused requests complete at once.
    a_simple_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser != bwgr_pkg::FUNC_QUERY) |=> s_tready)
        else $error("busy after a single-cycle request");

endmodule

bind braille_waveform_glyph_raster bwgr_checker u_bwgr_checker (.*);

@@ bench/braille_waveform_glyph_raster_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// braille_waveform_glyph_raster_tb: self-checking bench of the glyph raster
// Streams store, count and query requests into the block and checks every
// returned dot pattern against a cycle-free model of the trace mapping kept
// in the bench. The stream sides stall at random in two pressure modes, not
// in a third; the grid registers take several sizes, extremes included.
// ============================================================================
module braille_waveform_glyph_raster_tb;

    // Function code that the block must ignore, and a register index that
    // selects no register.
    localparam logic [bwgr_pkg::FUNC_W-1:0]    FUNC_NONE  = 2'd3;
    localparam logic [bwgr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int SAMPLE_DEPTH = bwgr_pkg::DEF_MAX_SAMPLES;
    localparam int SAMPLE_AW    = $clog2(SAMPLE_DEPTH);
    localparam int DRAIN_CYCLES = 120;

    // One request as it travels on the input stream.
    typedef struct packed {
        logic [bwgr_pkg::FUNC_W-1:0] func;
        logic [bwgr_pkg::IDX_W-1:0]  sample_index;
        logic [bwgr_pkg::VAL_W-1:0]  sample_value;
        logic [bwgr_pkg::CROW_W-1:0] cell_row;
        logic [bwgr_pkg::CCOL_W-1:0] cell_col;
    } raster_req_t;

    // One glyph answer: the Braille dots and the outside-of-grid flag.
    typedef struct packed {
        logic [bwgr_pkg::PAT_W-1:0] dots;
        logic                       off_grid;
    } glyph_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bwgr_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic [bwgr_pkg::FUNC_W-1:0]     s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bwgr_pkg::PAT_W-1:0]      m_tdata;
    logic                            m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bwgr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [bwgr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    braille_waveform_glyph_raster u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench copy of the block state. The sample memory starts unknown, just as
    // in the block; every sample that a query reads is stored before it.
    // ------------------------------------------------------------------------
    logic [bwgr_pkg::VAL_W-1:0]      sample_mem [SAMPLE_DEPTH];
    int unsigned                     win_count = 0;
    logic [bwgr_pkg::ROWS_CFG_W-1:0] grid_rows_q = bwgr_pkg::GRID_ROWS_RESET;
    logic [bwgr_pkg::COLS_CFG_W-1:0] grid_cols_q = bwgr_pkg::GRID_COLS_RESET;

    // Window and written entries as seen when requests are queued, so that
    // queries can be preceded by the stores they depend on.
    int unsigned plan_count = 0;
    bit          plan_written [SAMPLE_DEPTH];

    raster_req_t pending_reqs[$];
    glyph_t      expected_glyphs[$];

    int fail_count     = 0;
    int results_seen   = 0;
    int queries_taken  = 0;
    int stores_taken   = 0;
    int requests_taken = 0;
    int cfg_writes     = 0;

    // Stall pressure: percent of cycles in which each side holds off.
    int src_idle_pct = 32;
    int snk_idle_pct = 53;

    // Register values above the maximum act as the maximum.
    function automatic int unsigned eff_rows();
        return (grid_rows_q > bwgr_pkg::DEF_MAX_ROWS) ? bwgr_pkg::DEF_MAX_ROWS
                                                      : int'(grid_rows_q);
    endfunction

    function automatic int unsigned eff_cols();
        return (grid_cols_q > bwgr_pkg::DEF_MAX_COLS) ? bwgr_pkg::DEF_MAX_COLS
                                                      : int'(grid_cols_q);
    endfunction

    // Sample that dot column x reads: x scaled onto the valid window.
    function automatic int unsigned sample_pick(input int unsigned x, input int unsigned count,
                                                input int unsigned dcols);
        int unsigned pick;
        pick = (x * count) / dcols;
        if (pick >= count)
            pick = count - 1;
        if (pick >= SAMPLE_DEPTH)
            pick = SAMPLE_DEPTH - 1;
        return pick;
    endfunction

    // Dot row where the trace crosses dot column x. With an empty window the
    // trace sits on the centre line because the sample then counts as zero.
    function automatic int unsigned trace_row(input int unsigned x, input int unsigned drows,
                                              input int unsigned dcols);
        int                s;
        longint unsigned   scaled;
        int unsigned       y;
        s = 0;
        if (win_count > 0)
            s = $signed(sample_mem[sample_pick(x, win_count, dcols)]);
        scaled = longint'(32768 - s) * longint'(drows - 1);
        y = int'(scaled >> 16);
        if (y > drows - 1)
            y = drows - 1;
        return y;
    endfunction

    // Braille dot weight: left column 0x01 0x02 0x04 then 0x40 at the bottom,
    // right column 0x08 0x10 0x20 then 0x80.
    function automatic logic [bwgr_pkg::PAT_W-1:0] braille_weight(input int unsigned dr,
                                                                  input int unsigned dc);
        logic [bwgr_pkg::PAT_W-1:0] w;
        if (dr < 3)
            w = 8'h01 << (dr + 3 * dc);
        else
            w = (dc == 0) ? 8'h40 : 8'h80;
        return w;
    endfunction

    // Expected answer to a glyph query under the current grid and window.
    function automatic glyph_t render_glyph(input raster_req_t r);
        glyph_t      g;
        int unsigned rows;
        int unsigned cols;
        int unsigned drows;
        int unsigned dcols;
        int unsigned x;
        int unsigned y;
        int unsigned py;
        int unsigned lo;
        int unsigned hi;
        int unsigned dy;
        int unsigned dc;
        int unsigned dr;
        rows = eff_rows();
        cols = eff_cols();
        g.dots = '0;
        g.off_grid = 1'b0;
        if (r.cell_row >= rows || r.cell_col >= cols)
        begin
            g.off_grid = 1'b1;
            return g;
        end
        drows = rows * 4;
        dcols = cols * 2;
        for (dc = 0; dc < 2; dc++)
        begin
            x = r.cell_col * 2 + dc;
            y = trace_row(x, drows, dcols);
            // The leftmost dot column joins onto itself only.
            py = (x > 0) ? trace_row(x - 1, drows, dcols) : y;
            lo = (y < py) ? y : py;
            hi = (y < py) ? py : y;
            for (dr = 0; dr < 4; dr++)
            begin
                dy = r.cell_row * 4 + dr;
                if (dy >= lo && dy <= hi)
                    g.dots = g.dots | braille_weight(dr, dc);
            end
        end
        return g;
    endfunction

    // Advance the bench state by one accepted request.
    function automatic void apply_request(input raster_req_t r);
        requests_taken++;
        case (r.func)
            bwgr_pkg::FUNC_STORE:
            begin
                // Addresses past the memory are dropped.
                if (r.sample_index < SAMPLE_DEPTH)
                    sample_mem[r.sample_index[SAMPLE_AW-1:0]] = r.sample_value;
                stores_taken++;
            end
            bwgr_pkg::FUNC_COUNT:
                win_count = (r.sample_index > SAMPLE_DEPTH) ? SAMPLE_DEPTH : r.sample_index;
            bwgr_pkg::FUNC_QUERY:
            begin
                expected_glyphs.push_back(render_glyph(r));
                queries_taken++;
            end
            default:
                ;
        endcase
    endfunction

    // Request driver. The item on the bus is kept in cur_req so that the bench
    // state can be advanced at the edge where it is taken.
    raster_req_t cur_req = '0;

    always @(posedge clk or negedge rst_n)
    begin : req_driver
        logic        go;
        raster_req_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            go = ($urandom_range(99) >= src_idle_pct);
            if (s_tvalid && s_tready)
                apply_request(cur_req);
            if (!s_tvalid || s_tready)
            begin
                if (go && pending_reqs.size() != 0)
                begin
                    nxt = pending_reqs.pop_front();
                    cur_req = nxt;
                    s_tvalid <= 1'b1;
                    s_tuser  <= nxt.func;
                    s_tdata  <= {6'd0, nxt.cell_col, nxt.cell_row, nxt.sample_value,
                                 nxt.sample_index};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: ready follows the receiver's stall pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Result monitor: each taken result is matched against the oldest answer
    // still owed by the block.
    always @(posedge clk)
    begin : glyph_monitor
        glyph_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: dots=%02h off_grid=%b", m_tdata, m_tuser);
            end
            else
            begin
                want = expected_glyphs.pop_front();
                results_seen++;
                if (m_tdata !== want.dots || m_tuser !== want.off_grid)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("glyph %0d: expected %02h/%b, got %02h/%b",
                                 results_seen, want.dots, want.off_grid, m_tdata, m_tuser);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request builders. Fields that a function does not use carry random
    // noise, which the block must disregard.
    // ------------------------------------------------------------------------
    function automatic raster_req_t noise_req(input logic [bwgr_pkg::FUNC_W-1:0] func);
        raster_req_t r;
        logic [31:0] rnd;
        r.func         = func;
        rnd            = $urandom;
        r.sample_index = rnd[11:0];
        r.sample_value = rnd[27:12];
        rnd            = $urandom;
        r.cell_row     = rnd[5:0];
        r.cell_col     = rnd[13:6];
        return r;
    endfunction

    task automatic push_store(input int unsigned idx, input logic [bwgr_pkg::VAL_W-1:0] val);
        raster_req_t r;
        r = noise_req(bwgr_pkg::FUNC_STORE);
        r.sample_index = idx[bwgr_pkg::IDX_W-1:0];
        r.sample_value = val;
        if (r.sample_index < SAMPLE_DEPTH)
            plan_written[r.sample_index[SAMPLE_AW-1:0]] = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic push_count(input int unsigned n);
        raster_req_t r;
        r = noise_req(bwgr_pkg::FUNC_COUNT);
        r.sample_index = n[bwgr_pkg::IDX_W-1:0];
        plan_count = (r.sample_index > SAMPLE_DEPTH) ? SAMPLE_DEPTH : r.sample_index;
        pending_reqs.push_back(r);
    endtask

    // Sample values lean toward full scale now and then.
    function automatic logic [bwgr_pkg::VAL_W-1:0] pick_sample();
        logic [31:0] rnd;
        rnd = $urandom;
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return rnd[15:0];
        endcase
    endfunction

    // A query inside the grid reads up to three samples; each of them that
    // has not been written yet is stored just ahead of the query.
    task automatic push_query(input int unsigned row, input int unsigned col);
        raster_req_t r;
        int unsigned pick;
        int unsigned x_lo;
        r = noise_req(bwgr_pkg::FUNC_QUERY);
        r.cell_row = row[bwgr_pkg::CROW_W-1:0];
        r.cell_col = col[bwgr_pkg::CCOL_W-1:0];
        if (plan_count != 0 && r.cell_row < eff_rows() && r.cell_col < eff_cols())
        begin
            x_lo = (r.cell_col == 0) ? 0 : r.cell_col * 2 - 1;
            for (int unsigned x = x_lo; x <= r.cell_col * 2 + 1; x++)
            begin
                pick = sample_pick(x, plan_count, eff_cols() * 2);
                if (!plan_written[pick])
                    push_store(pick, pick_sample());
            end
        end
        pending_reqs.push_back(r);
    endtask

    // Window sizes: mostly short ones, with clears and saturating ones.
    function automatic int unsigned pick_count();
        case ($urandom_range(9))
            0:       return 0;
            1:       return $urandom_range(4095, 2049);
            2:       return $urandom_range(2048, 65);
            default: return $urandom_range(64, 1);
        endcase
    endfunction

    // A query that mostly lands inside the grid, with the outer columns
    // favored since they take the edge paths of the trace.
    task automatic push_grid_query();
        int unsigned rows;
        int unsigned cols;
        int unsigned row;
        int unsigned col;
        rows = eff_rows();
        cols = eff_cols();
        row = (rows == 0) ? $urandom_range(63) : $urandom_range(rows - 1);
        case ($urandom_range(9))
            0:       col = 0;
            1:       col = (cols == 0) ? 0 : cols - 1;
            default: col = (cols == 0) ? $urandom_range(255) : $urandom_range(cols - 1);
        endcase
        push_query(row, col);
    endtask

    // Random traffic: mostly store bursts, often followed by a window change,
    // and a few queries, the rest loose queries and stray requests. Ignored
    // requests are not counted toward n.
    task automatic random_traffic(input int n);
        int made;
        int k;
        int nst;
        int nq;
        made = 0;
        while (made < n)
        begin
            k = $urandom_range(99);
            if (k < 70)
            begin
                nst = $urandom_range(6);
                for (int i = 0; i < nst; i++)
                begin
                    if ($urandom_range(9) == 0)
                        push_store($urandom_range(4095, SAMPLE_DEPTH), pick_sample());
                    else
                        push_store($urandom_range(SAMPLE_DEPTH - 1), pick_sample());
                end
                made += nst;
                if ($urandom_range(2) != 0)
                begin
                    push_count(pick_count());
                    made++;
                end
                nq = $urandom_range(5, 1);
                for (int i = 0; i < nq; i++)
                    push_grid_query();
                made += nq;
            end
            else if (k < 90)
            begin
                push_query($urandom_range(63), $urandom_range(255));
                made++;
            end
            else
            begin
                pending_reqs.push_back(noise_req(FUNC_NONE));
            end
        end
    endtask

    // Wait until every request is taken and every answer has come back, then
    // give a trailing store time to land.
    task automatic settle();
        while (pending_reqs.size() != 0 || s_tvalid || expected_glyphs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid_reg(input logic [bwgr_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[bwgr_pkg::CFG_DATA_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            bwgr_pkg::REG_GRID_ROWS: grid_rows_q = value[bwgr_pkg::ROWS_CFG_W-1:0];
            bwgr_pkg::REG_GRID_COLS: grid_cols_q = value[bwgr_pkg::COLS_CFG_W-1:0];
            default:                 ;
        endcase
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols);
        settle();
        write_grid_reg(bwgr_pkg::REG_GRID_ROWS, rows);
        write_grid_reg(bwgr_pkg::REG_GRID_COLS, cols);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset grid of 16 x 80 glyphs and an empty window: the trace is the
        // centre line, which sits in the bottom dots of glyph row 7.
        push_query(0, 0);
        push_query(7, 79);
        push_query(7, 0);
        // Queries just past the grid and at the far corner of the field range.
        push_query(16, 0);
        push_query(0, 80);
        push_query(63, 255);
        pending_reqs.push_back(noise_req(FUNC_NONE));

        // Full-scale samples; stores past the memory must not alias onto it.
        push_store(0, 16'h7FFF);
        push_store(SAMPLE_DEPTH, 16'h8000);
        push_store(4095, 16'h8000);
        push_store(1, 16'h8000);
        push_count(1);
        push_query(0, 0);
        push_query(15, 40);
        // Two samples: a full-height step at the middle of the grid.
        push_count(2);
        push_query(0, 40);
        push_query(8, 40);
        push_query(15, 39);

        // Saturating and full windows, then a zero count that clears the
        // window back to the centre line.
        push_count(4095);
        push_query(0, 0);
        push_query(15, 79);
        push_query(7, 40);
        push_count(SAMPLE_DEPTH);
        push_query(8, 20);
        push_count(0);
        push_query(7, 10);
        random_traffic(80);

        // Smallest grid, then the largest, then register values beyond it.
        set_grid(1, 1);
        random_traffic(80);
        set_grid(bwgr_pkg::DEF_MAX_ROWS, bwgr_pkg::DEF_MAX_COLS);
        random_traffic(80);

        settle();
        src_idle_pct = 53;
        snk_idle_pct = 32;
        set_grid(127, 511);
        random_traffic(80);
        // No rows: every query lands outside the grid.
        set_grid(0, $urandom_range(511));
        write_grid_reg(REG_UNUSED, $urandom_range(511));
        random_traffic(50);
        set_grid($urandom_range(6, 1), $urandom_range(40, 1));
        random_traffic(90);

        settle();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // No columns.
        set_grid($urandom_range(127, 1), 0);
        random_traffic(50);
        set_grid($urandom_range(8, 1), $urandom_range(511, 1));
        random_traffic(90);

        settle();
        if (expected_glyphs.size() != 0)
        begin
            fail_count += expected_glyphs.size();
            $display("%0d glyph answers never arrived", expected_glyphs.size());
        end
        $display("Covered %0d requests (%0d stores, %0d queries), %0d register writes;",
                 requests_taken, stores_taken, queries_taken, cfg_writes);
        $display("%0d glyph answers were checked, %0d failures.", results_seen, fail_count);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("watchdog expired with %0d answers outstanding", expected_glyphs.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bwgr_pkg.sv
rtl/bwgr_div.sv
rtl/braille_waveform_glyph_raster.sv
rtl/bwgr_checker.sv
bench/braille_waveform_glyph_raster_tb.sv
